FILE: src/hsm_pkg.sv
// ----------------------------------------------------------------------------
// hsm_pkg: shared types and constants of the hotkey sequence matcher
// Item layouts, result codes, register indexes and the control and status
// groups that pass between the top level and the match core.
// ----------------------------------------------------------------------------
`default_nettype none

package hsm_pkg;

  // Default sizes of the stores.
  localparam int KEY_ENTRIES_DEF  = 256;
  localparam int FUNC_ENTRIES_DEF = 64;
  localparam int EVENT_DEPTH_DEF  = 16;

  // Field widths fixed by the item layouts.
  localparam int SEQ_W      = 9;
  localparam int GROUP_W    = 6;
  localparam int CODE_W     = 15;
  localparam int MOD_W      = 12;
  localparam int WORD_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Bit 15 of an entry word: release flag (code), group head (require) or sequence head (forbid).
  localparam int HEAD_BIT = 15;

  // Item modes.
  localparam logic [1:0] MODE_KEY_WR  = 2'd0;
  localparam logic [1:0] MODE_FUNC_WR = 2'd1;
  localparam logic [1:0] MODE_EVENT   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_MATCH    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_CONT     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAILED   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_FIRST = 2'd2;

  // Input item.
  typedef struct packed {
    logic [1:0]               mode;
    logic [7:0]               slot;
    logic [WORD_W-1:0]        entry_code;
    logic [WORD_W-1:0]        entry_require;
    logic [WORD_W-1:0]        entry_forbid;
    logic signed [ADDR_W-1:0] target_addr;
    logic [CODE_W-1:0]        key_code;
    logic                     is_make;
    logic [MOD_W-1:0]         modifiers;
  } hsm_in_t;

  // Result item.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [ADDR_W-1:0] func_addr;
  } hsm_out_t;

  // One key table entry.
  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic [WORD_W-1:0] require;
    logic [WORD_W-1:0] forbid;
  } hsm_key_t;

  // One buffered key event.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              make;
    logic [MOD_W-1:0]  mods;
  } hsm_event_t;

  // Outcome of a table walk.
  typedef enum logic [1:0] {
    RC_MATCH,
    RC_CONT,
    RC_NONE
  } hsm_rc_e;

  // Top level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FETCH,
    ST_RESP
  } hsm_state_e;

  // Match core walk states.
  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_REDUCE,
    WALK_SCAN
  } hsm_walk_e;

  // Commands from the top level to the match core.
  typedef struct packed {
    logic push;
    logic clear;
    logic drop;
    logic start;
  } hsm_ctrl_t;

  // Status from the match core to the top level.
  typedef struct packed {
    logic    busy;
    logic    done;
    logic    full;
    hsm_rc_e rc;
  } hsm_stat_t;

endpackage : hsm_pkg

`default_nettype wire

FILE: src/hotkey_sequence_matcher.sv
// ----------------------------------------------------------------------------
// hotkey_sequence_matcher: key sequence matcher with loadable tables
// Buffers key events and matches them against a loaded table of key
// sequences, returning the function address of the matched group.
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+----------------------------
//   cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//   in       | in        | in_valid_i / in_ready_o| in_data_i  (hsm_in_t)
//   out      | out       | out_valid_o/out_ready_i| out_data_o (hsm_out_t)
//
// A table write or spare mode item passes through the pending result register
// into the result register. A key event takes R = group_first / FUNC_ENTRIES
// reduction steps (0 by default), then walks at most N key table entries, one
// per cycle through the key memory read port (N = clipped seq_limit - seq_first,
// 0 for an empty window); the sequencer starts and ends the walk, fetches the
// function address on a match and loads the result. Reset clears the
// configuration registers, the result valid flag, the event count and the
// control state; the tables are undefined until written. The block takes the next
// item while a result waits, but then holds its own result until that is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hotkey_sequence_matcher #(
  parameter int KEY_ENTRIES  = hsm_pkg::KEY_ENTRIES_DEF,
  parameter int FUNC_ENTRIES = hsm_pkg::FUNC_ENTRIES_DEF,
  parameter int EVENT_DEPTH  = hsm_pkg::EVENT_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [hsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [hsm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire hsm_pkg::hsm_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output hsm_pkg::hsm_out_t                    out_data_o
);
  import hsm_pkg::*;

  localparam int KAW = $clog2(KEY_ENTRIES);
  localparam int FAW = (FUNC_ENTRIES > 1) ? $clog2(FUNC_ENTRIES) : 1;

  hsm_state_e               state_q, state_d;
  logic [SEQ_W-1:0]         seq_first_q;
  logic [SEQ_W-1:0]         seq_limit_q;
  logic [GROUP_W-1:0]       group_first_q;
  logic                     accept;
  logic                     key_slot_ok;
  logic                     func_slot_ok;
  logic                     key_wr_en;
  logic                     func_wr_en;
  logic                     func_rd_en;
  hsm_key_t                 key_wr_data;
  hsm_event_t               ev_in;
  hsm_ctrl_t                core_ctrl;
  hsm_stat_t                core_stat;
  logic [FAW-1:0]           core_grp;
  logic [ADDR_W-1:0]        func_mem [FUNC_ENTRIES];
  logic [ADDR_W-1:0]        func_rdata_q;
  logic                     make_q;
  logic                     pend_load;
  logic [STATUS_W-1:0]      pend_status_d, pend_status_q;
  logic [ADDR_W-1:0]        pend_addr_d, pend_addr_q;
  logic                     out_load;
  logic                     out_valid_q;
  hsm_out_t                 out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_first_q   <= '0;
      seq_limit_q   <= '0;
      group_first_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEQ_FIRST:   seq_first_q   <= cfg_wdata_i;
        CFG_SEQ_LIMIT:   seq_limit_q   <= cfg_wdata_i;
        CFG_GROUP_FIRST: group_first_q <= cfg_wdata_i[GROUP_W-1:0];
        default: ;
      endcase
    end
  end

  // Item fields as seen by the tables.
  assign accept       = in_valid_i && in_ready_o;
  assign key_slot_ok  = (32'(in_data_i.slot) < KEY_ENTRIES);
  assign func_slot_ok = (32'(in_data_i.slot) < FUNC_ENTRIES);
  assign key_wr_data  = '{code:    in_data_i.entry_code,
                          require: in_data_i.entry_require,
                          forbid:  in_data_i.entry_forbid};
  assign ev_in        = '{code: in_data_i.key_code,
                          make: in_data_i.is_make,
                          mods: in_data_i.modifiers};

  hsm_match_core #(
    .KEY_ENTRIES  (KEY_ENTRIES),
    .FUNC_ENTRIES (FUNC_ENTRIES),
    .EVENT_DEPTH  (EVENT_DEPTH),
    .KAW          (KAW),
    .FAW          (FAW)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_wr_en_i   (key_wr_en),
    .key_wr_addr_i (KAW'(in_data_i.slot)),
    .key_wr_data_i (key_wr_data),
    .event_i       (ev_in),
    .ctrl_i        (core_ctrl),
    .seq_first_i   (seq_first_q),
    .seq_limit_i   (seq_limit_q),
    .group_first_i (group_first_q),
    .status_o      (core_stat),
    .grp_o         (core_grp)
  );

  // Function address memory.
  always_ff @(posedge clk_i) begin
    if (func_wr_en) begin
      func_mem[FAW'(in_data_i.slot)] <= in_data_i.target_addr;
    end
    if (func_rd_en) begin
      func_rdata_q <= func_mem[core_grp];
    end
  end

  // Next state of the item sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.mode == MODE_EVENT && !core_stat.full) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        if (core_stat.done) begin
          state_d = (core_stat.rc == RC_MATCH) ? ST_FETCH : ST_RESP;
        end
      end
      ST_FETCH: state_d = ST_RESP;
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: table writes, core commands and the pending result.
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    key_wr_en     = 1'b0;
    func_wr_en    = 1'b0;
    func_rd_en    = 1'b0;
    core_ctrl     = '0;
    pend_load     = 1'b0;
    pend_status_d = STATUS_WRITTEN;
    pend_addr_d   = '0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend_load = 1'b1;
          case (in_data_i.mode)
            MODE_KEY_WR:  key_wr_en  = key_slot_ok;
            MODE_FUNC_WR: func_wr_en = func_slot_ok;
            MODE_EVENT: begin
              if (core_stat.full) begin
                core_ctrl.clear = 1'b1;
                pend_status_d   = STATUS_OVERFLOW;
              end else begin
                core_ctrl.push  = 1'b1;
                core_ctrl.start = 1'b1;
                pend_load       = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (core_stat.done) begin
          case (core_stat.rc)
            RC_MATCH: begin
              core_ctrl.clear = 1'b1;
              func_rd_en      = 1'b1;
            end
            RC_CONT: begin
              pend_load     = 1'b1;
              pend_status_d = STATUS_CONT;
            end
            default: begin
              // No sequence fits: a release is dropped, a press clears all.
              pend_load = 1'b1;
              if (make_q) begin
                core_ctrl.clear = 1'b1;
                pend_status_d   = STATUS_FAILED;
              end else begin
                core_ctrl.drop = 1'b1;
                pend_status_d  = STATUS_IGNORED;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        pend_load     = 1'b1;
        pend_status_d = STATUS_MATCH;
        pend_addr_d   = func_rdata_q;
      end
      ST_RESP: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Make flag of the event being walked, and the pending result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      make_q <= in_data_i.is_make;
    end
    if (pend_load) begin
      pend_status_q <= pend_status_d;
      pend_addr_q   <= pend_addr_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.status    <= pend_status_q;
      out_q.func_addr <= pend_addr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // While the sequencer waits on a walk, the core is working on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> core_stat.busy)
    else $error("sequencer waiting on an idle core");

  // A new result only appears after the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == ST_RESP)
    else $error("result loaded outside the response state");

  // A match always moves to the fetch state in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    func_rd_en |=> state_q == ST_FETCH)
    else $error("function fetch without fetch state");

  // Table writes only happen when an item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_wr_en || func_wr_en) |-> accept && !core_stat.busy)
    else $error("table write outside an accepted item");

endmodule : hotkey_sequence_matcher

`default_nettype wire

FILE: src/hsm_match_core.sv
// ----------------------------------------------------------------------------
// hsm_match_core: key table, event buffer and sequence walk
// Holds the key table in a synchronous memory and the buffered events, and
// walks the active part of the table one entry a cycle against the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module hsm_match_core #(
  parameter int KEY_ENTRIES  = hsm_pkg::KEY_ENTRIES_DEF,
  parameter int FUNC_ENTRIES = hsm_pkg::FUNC_ENTRIES_DEF,
  parameter int EVENT_DEPTH  = hsm_pkg::EVENT_DEPTH_DEF,
  parameter int KAW          = $clog2(KEY_ENTRIES),
  parameter int FAW          = (FUNC_ENTRIES > 1) ? $clog2(FUNC_ENTRIES) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         key_wr_en_i,
  input  wire logic [KAW-1:0]               key_wr_addr_i,
  input  wire hsm_pkg::hsm_key_t            key_wr_data_i,
  input  wire hsm_pkg::hsm_event_t          event_i,
  input  wire hsm_pkg::hsm_ctrl_t           ctrl_i,
  input  wire logic [hsm_pkg::SEQ_W-1:0]    seq_first_i,
  input  wire logic [hsm_pkg::SEQ_W-1:0]    seq_limit_i,
  input  wire logic [hsm_pkg::GROUP_W-1:0]  group_first_i,
  output hsm_pkg::hsm_stat_t                status_o,
  output logic [FAW-1:0]                    grp_o
);
  import hsm_pkg::*;

  localparam int PW_RAW = $clog2(KEY_ENTRIES + 1);
  localparam int PW     = (PW_RAW > SEQ_W) ? PW_RAW : SEQ_W;
  localparam int GW     = (FAW > GROUP_W) ? FAW : GROUP_W;
  localparam int CW     = $clog2(EVENT_DEPTH + 1);
  localparam int BW     = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

  // Does a key table entry accept a buffered event?
  function automatic logic entry_hit(hsm_key_t k, hsm_event_t ev);
    logic code_ok;
    logic make_ok;
    logic req_ok;
    logic forb_ok;
    code_ok = (k.code[CODE_W-1:0] == ev.code);
    make_ok = (ev.make == !k.code[HEAD_BIT]);
    req_ok  = ((k.require[MOD_W-1:0] & ~ev.mods) == '0);
    forb_ok = ((k.forbid[MOD_W-1:0] & ev.mods) == '0);
    return code_ok && make_ok && req_ok && forb_ok;
  endfunction

  hsm_walk_e            state_q, state_d;
  hsm_key_t             key_mem [KEY_ENTRIES];
  hsm_key_t             key_rdata_q;
  hsm_event_t           ev_buf [EVENT_DEPTH];
  logic [CW-1:0]        count_q;
  logic [PW-1:0]        e_q;
  logic [PW-1:0]        first_q;
  logic [PW-1:0]        lim_q;
  logic [PW-1:0]        lim_d;
  logic [PW-1:0]        rd_pos;
  logic [CW-1:0]        sp_q, sp_d;
  logic                 alive_q, alive_d;
  logic [GW-1:0]        grp_q;
  logic [GW-1:0]        grp_inc;
  logic                 grp_big;
  logic                 grp_step;
  logic                 at_end;
  logic                 is_first;
  logic                 seq_head;
  logic                 brk;
  logic                 hit;
  hsm_event_t           ev_sel;
  logic                 scan_done;
  hsm_rc_e              scan_rc;

  // Key table memory: written by the top level while idle, read every cycle.
  assign rd_pos = (state_q == WALK_SCAN) ? e_q + PW'(1) : e_q;

  always_ff @(posedge clk_i) begin
    if (key_wr_en_i) begin
      key_mem[key_wr_addr_i] <= key_wr_data_i;
    end
    key_rdata_q <= key_mem[rd_pos[KAW-1:0]];
  end

  // Event buffer: appended at the fill count.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      ev_buf[count_q[BW-1:0]] <= event_i;
    end
  end

  // Fill count of the event buffer; clearing wins over dropping the last item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.drop) begin
      count_q <= count_q - CW'(1);
    end else if (ctrl_i.push) begin
      count_q <= count_q + CW'(1);
    end
  end

  // Active table limit, clipped to the table size.
  assign lim_d = (PW'(seq_limit_i) > PW'(KEY_ENTRIES)) ? PW'(KEY_ENTRIES) : PW'(seq_limit_i);

  // Group index housekeeping: reduction into range and wrapping increment.
  assign grp_big = (32'(grp_q) >= FUNC_ENTRIES);
  assign grp_inc = ((32'(grp_q) + 1) >= FUNC_ENTRIES) ? '0 : grp_q + GW'(1);

  // Per-entry decision of the walk.
  assign at_end   = (e_q >= lim_q);
  assign is_first = (e_q == first_q);
  assign brk      = key_rdata_q.forbid[HEAD_BIT];
  assign seq_head = is_first || brk;
  assign ev_sel   = ev_buf[seq_head ? '0 : sp_q[BW-1:0]];
  assign hit      = entry_hit(key_rdata_q, ev_sel);

  always_comb begin
    scan_done = 1'b0;
    scan_rc   = RC_NONE;
    sp_d      = sp_q;
    alive_d   = alive_q;
    grp_step  = 1'b0;
    if (alive_q && (sp_q == count_q)) begin
      // Whole buffer consumed: a match if the sequence ends here.
      scan_done = 1'b1;
      scan_rc   = (at_end || brk) ? RC_MATCH : RC_CONT;
    end else if (at_end) begin
      scan_done = 1'b1;
      scan_rc   = RC_NONE;
    end else if (seq_head) begin
      // A new sequence starts; later group heads move to the next address.
      grp_step = !is_first && key_rdata_q.require[HEAD_BIT];
      alive_d  = hit;
      sp_d     = hit ? CW'(1) : '0;
    end else if (alive_q) begin
      if (hit) begin
        sp_d = sp_q + CW'(1);
      end else begin
        alive_d = 1'b0;
      end
    end
  end

  // Next state of the walk.
  always_comb begin
    state_d = state_q;
    case (state_q)
      WALK_IDLE: begin
        if (ctrl_i.start) begin
          state_d = WALK_REDUCE;
        end
      end
      WALK_REDUCE: begin
        if (!grp_big) begin
          state_d = WALK_SCAN;
        end
      end
      WALK_SCAN: begin
        if (scan_done) begin
          state_d = WALK_IDLE;
        end
      end
      default: state_d = WALK_IDLE;
    endcase
  end

  // Status towards the top level.
  always_comb begin
    status_o.busy = (state_q != WALK_IDLE);
    status_o.done = (state_q == WALK_SCAN) && scan_done;
    status_o.full = (count_q >= CW'(EVENT_DEPTH));
    status_o.rc   = scan_rc;
    grp_o         = grp_q[FAW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WALK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q     <= '0;
      first_q <= '0;
      lim_q   <= '0;
      sp_q    <= '0;
      alive_q <= 1'b0;
      grp_q   <= '0;
    end else begin
      case (state_q)
        WALK_IDLE: begin
          if (ctrl_i.start) begin
            e_q     <= PW'(seq_first_i);
            first_q <= PW'(seq_first_i);
            lim_q   <= lim_d;
            sp_q    <= '0;
            alive_q <= 1'b0;
            grp_q   <= GW'(group_first_i);
          end
        end
        WALK_REDUCE: begin
          if (grp_big) begin
            grp_q <= grp_q - GW'(FUNC_ENTRIES);
          end
        end
        WALK_SCAN: begin
          if (!scan_done) begin
            e_q     <= e_q + PW'(1);
            sp_q    <= sp_d;
            alive_q <= alive_d;
            if (grp_step) begin
              grp_q <= grp_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The buffer never holds more items than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(EVENT_DEPTH))
    else $error("event buffer count beyond depth");

  // An item is only appended when there is room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.push |-> !status_o.full)
    else $error("push into a full event buffer");

  // A walk is only started from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.start |-> state_q == WALK_IDLE)
    else $error("walk started while busy");

  // A live sequence never runs past the buffered items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WALK_SCAN && alive_q) |-> sp_q <= count_q)
    else $error("sequence position beyond buffer");

  // Once done, the walk is idle in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) status_o.done |=> !status_o.busy)
    else $error("walk did not return to idle");

endmodule : hsm_match_core

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the hotkey sequence matcher
// Loads the key and function tables through table write items, then plays
// directed cases (empty window, buffer overflow, break entries, modifier
// masks, group wrap) and a long random run made mostly of well-formed key
// sequences taken from the loaded table, mixed with stray events, table
// rewrites and spare-mode items. Every accepted item is run through a
// cycle-free predictor, and each result is compared with the oldest
// predicted outcome. Both channels idle at random.
// ----------------------------------------------------------------------------

module testbench;
  import hsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned RANDOM_PHASES = 8;
  // The package names three modes; the fourth is answered as a table write.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Predictor of the matcher with its own tables, event buffer and registers.
  class hotkey_tracker;
    hsm_key_t             keys [KEY_ENTRIES_DEF];
    logic [ADDR_W-1:0]    funcs [FUNC_ENTRIES_DEF];
    hsm_event_t           held [EVENT_DEPTH_DEF];
    int unsigned          held_count;
    logic [SEQ_W-1:0]     seq_first;
    logic [SEQ_W-1:0]     seq_limit;
    logic [GROUP_W-1:0]   group_first;
    hsm_out_t             awaited_outcomes [$];
    int unsigned          outcome_tally [6];
    int unsigned          mismatches;

    function new();
      held_count  = 0;
      seq_first   = '0;
      seq_limit   = '0;
      group_first = '0;
      mismatches  = 0;
      foreach (outcome_tally[i]) outcome_tally[i] = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SEQ_FIRST:   seq_first = data;
        CFG_SEQ_LIMIT:   seq_limit = data;
        CFG_GROUP_FIRST: group_first = data[GROUP_W-1:0];
        default: ;
      endcase
    endfunction

    // An entry past the window or flagged in its forbid word opens a sequence.
    function bit is_head(input int unsigned idx, input int unsigned lim);
      if (idx >= lim) return 1'b1;
      return keys[idx].forbid[HEAD_BIT];
    endfunction

    function bit fits(input hsm_key_t k, input hsm_event_t ev);
      if (k.code[CODE_W-1:0] != ev.code) return 1'b0;
      if (ev.make != !k.code[HEAD_BIT]) return 1'b0;
      if ((k.require[MOD_W-1:0] & ~ev.mods) != '0) return 1'b0;
      if ((k.forbid[MOD_W-1:0] & ev.mods) != '0) return 1'b0;
      return 1'b1;
    endfunction

    // Compares the buffered events with the sequence that starts at start.
    function hsm_rc_e try_sequence(input int unsigned start, input int unsigned lim);
      int unsigned depth;
      int unsigned pos;
      depth = 0;
      pos = start;
      while (depth < held_count && pos < lim && (depth == 0 || !is_head(pos, lim))) begin
        if (!fits(keys[pos], held[depth])) break;
        depth++;
        pos++;
      end
      if (depth == held_count) return is_head(pos, lim) ? RC_MATCH : RC_CONT;
      return RC_NONE;
    endfunction

    // Works out the outcome of one accepted item and queues it.
    function void note_item(input hsm_in_t it);
      hsm_out_t           res;
      hsm_event_t         ev;
      hsm_rc_e            rc;
      int unsigned        lim;
      int unsigned        pos;
      logic [GROUP_W-1:0] grp;
      res.status    = STATUS_WRITTEN;
      res.func_addr = '0;
      case (it.mode)
        MODE_KEY_WR: begin
          keys[it.slot] = {it.entry_code, it.entry_require, it.entry_forbid};
        end
        MODE_FUNC_WR: begin
          if (it.slot < FUNC_ENTRIES_DEF) funcs[it.slot] = it.target_addr;
        end
        MODE_EVENT: begin
          if (held_count >= EVENT_DEPTH_DEF) begin
            held_count = 0;
            res.status = STATUS_OVERFLOW;
          end else begin
            ev.code = it.key_code;
            ev.make = it.is_make;
            ev.mods = it.modifiers;
            held[held_count] = ev;
            held_count++;
            lim = (seq_limit > KEY_ENTRIES_DEF) ? KEY_ENTRIES_DEF : seq_limit;
            pos = seq_first;
            // The group index is six bits wide, so it wraps with the table.
            grp = group_first;
            rc = RC_NONE;
            while (pos < lim) begin
              rc = try_sequence(pos, lim);
              if (rc != RC_NONE) break;
              pos++;
              while (!is_head(pos, lim)) pos++;
              if (pos < lim && keys[pos].require[HEAD_BIT]) grp = grp + 1'b1;
            end
            if (rc == RC_MATCH) begin
              held_count = 0;
              res.status = STATUS_MATCH;
              res.func_addr = funcs[grp];
            end else if (rc == RC_CONT) begin
              res.status = STATUS_CONT;
            end else if (!ev.make) begin
              held_count--;
              res.status = STATUS_IGNORED;
            end else begin
              held_count = 0;
              res.status = STATUS_FAILED;
            end
          end
        end
        default: ;
      endcase
      outcome_tally[res.status]++;
      awaited_outcomes.push_back(res);
    endfunction

    function void check_result(input hsm_out_t got);
      hsm_out_t want;
      if (awaited_outcomes.size() == 0) begin
        $error("result with no item waiting: status %0d, func_addr %h",
               got.status, got.func_addr);
        mismatches++;
        return;
      end
      want = awaited_outcomes.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.func_addr !== want.func_addr) begin
        $error("func_addr: expected %h, got %h", want.func_addr, got.func_addr);
        mismatches++;
      end
    endfunction

    function int unsigned awaited();
      return awaited_outcomes.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  hsm_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  hsm_out_t              out_data_o;

  hotkey_tracker book = new();
  bit            steady;
  int unsigned   items_sent;
  int unsigned   settings_used;
  int unsigned   cycle_count = 0;

  hotkey_sequence_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Every result taken by the bench is checked against the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) book.check_result(out_data_o);
  end

  // Mostly short gaps, now and then a long one, none in steady stretches.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Fields that the mode does not use still carry random bits.
  function automatic hsm_in_t random_item(input logic [1:0] mode);
    logic [127:0] raw;
    hsm_in_t      it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(hsm_in_t)-1:0];
    it.mode = mode;
    return it;
  endfunction

  function automatic logic [MOD_W-1:0] sparse_mask();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return '0;
    if (r < 9) return MOD_W'(1) << $urandom_range(0, MOD_W - 1);
    return MOD_W'($urandom);
  endfunction

  // Table entry drawn from a small set of scan codes so that sequences overlap.
  function automatic hsm_key_t random_entry();
    hsm_key_t k;
    k.code = {($urandom_range(0, 4) == 0), 15'($urandom_range(0, 11))};
    if ($urandom_range(0, 19) == 0) k.code[CODE_W-1:0] = CODE_W'($urandom);
    k.require = {($urandom_range(0, 3) == 0), 3'($urandom), sparse_mask()};
    k.forbid  = {($urandom_range(0, 2) == 0), 3'($urandom), sparse_mask()};
    return k;
  endfunction

  // Presents one item and returns at the edge where it is taken.
  task automatic send_item(input hsm_in_t it);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    book.note_item(it);
    if (it.mode != MODE_SPARE) items_sent++;
  endtask

  task automatic send_event(input logic [CODE_W-1:0] code, input logic make,
                            input logic [MOD_W-1:0] mods);
    hsm_in_t it;
    it = random_item(MODE_EVENT);
    it.key_code  = code;
    it.is_make   = make;
    it.modifiers = mods;
    send_item(it);
  endtask

  task automatic write_key(input logic [7:0] slot, input hsm_key_t k);
    hsm_in_t it;
    it = random_item(MODE_KEY_WR);
    it.slot = slot;
    {it.entry_code, it.entry_require, it.entry_forbid} = k;
    send_item(it);
  endtask

  task automatic write_func(input logic [7:0] slot, input logic [ADDR_W-1:0] addr);
    hsm_in_t it;
    it = random_item(MODE_FUNC_WR);
    it.slot = slot;
    it.target_addr = addr;
    send_item(it);
  endtask

  task automatic stray_event(input logic make);
    logic [CODE_W-1:0] code;
    code = ($urandom_range(0, 7) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(0, 11));
    send_event(code, make, MOD_W'($urandom));
  endtask

  // Drops valid and waits until every predicted outcome has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (book.awaited() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    book.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [SEQ_W-1:0] first, input logic [SEQ_W-1:0] limit,
                              input logic [GROUP_W-1:0] grp);
    write_reg(CFG_SEQ_FIRST, first);
    write_reg(CFG_SEQ_LIMIT, limit);
    write_reg(CFG_GROUP_FIRST, CFG_DATA_W'(grp));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Plays the events that one stored sequence asks for, up to max_len of them.
  task automatic play_sequence(input int unsigned max_len);
    int unsigned lim;
    int unsigned start;
    int unsigned probe;
    int unsigned pos;
    int unsigned n;
    hsm_key_t    k;
    lim = (book.seq_limit > KEY_ENTRIES_DEF) ? KEY_ENTRIES_DEF : book.seq_limit;
    if (book.seq_first >= lim) begin
      stray_event($urandom_range(0, 1));
      return;
    end
    start = book.seq_first;
    repeat (6) begin
      probe = $urandom_range(book.seq_first, lim - 1);
      if (book.keys[probe].forbid[HEAD_BIT]) start = probe;
    end
    pos = start;
    n = 0;
    do begin
      k = book.keys[pos];
      send_event(k.code[CODE_W-1:0], !k.code[HEAD_BIT],
                 ((MOD_W'($urandom) & MOD_W'($urandom)) & ~k.forbid[MOD_W-1:0]) |
                 k.require[MOD_W-1:0]);
      pos++;
      n++;
    end while (pos < lim && !book.keys[pos].forbid[HEAD_BIT] && n < max_len);
  endtask

  // Fills both tables so that no walk ever reads an unwritten entry.
  task automatic load_tables();
    hsm_key_t k;
    for (int s = 0; s < FUNC_ENTRIES_DEF; s++) begin
      case (s)
        0:       write_func(8'(s), 32'h8000_0000);
        1:       write_func(8'(s), 32'h0000_0000);
        2:       write_func(8'(s), 32'hffff_ffff);
        63:      write_func(8'(s), 32'h7fff_ffff);
        default: write_func(8'(s), $urandom);
      endcase
    end
    for (int s = 0; s < KEY_ENTRIES_DEF; s++) begin
      if (s < 20) begin
        // One sequence of twenty presses, longer than the event buffer.
        k.code    = 16'h0100 + 16'(s);
        k.require = '0;
        k.forbid  = (s == 0) ? 16'h8000 : 16'h0000;
      end else if (s == 20) begin
        // Needs every modifier; unused mask bits set.
        k = {16'h7fff, 16'hffff, 16'hf000};
      end else if (s == 21) begin
        // Release of scan code zero with every modifier forbidden.
        k = {16'h8000, 16'h0000, 16'h0fff};
      end else if (s == 22) begin
        k = {16'h0005, 16'h8001, 16'h8800};
      end else if (s == 23) begin
        k = {16'h0006, 16'h0000, 16'h8000};
      end else begin
        k = random_entry();
      end
      write_key(8'(s), k);
    end
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned mark;
    int unsigned r;
    hsm_key_t    k;
    hsm_in_t     it;
    mark = items_sent;
    while (items_sent - mark < quota) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        play_sequence(EVENT_DEPTH_DEF);
      end else if (r < 70) begin
        // A sequence cut short and followed by a stray key.
        play_sequence($urandom_range(1, 3));
        stray_event($urandom_range(0, 1));
      end else if (r < 80) begin
        stray_event(1'b1);
      end else if (r < 88) begin
        k = ($urandom_range(0, 3) == 0) ? {16'($urandom), 16'($urandom), 16'($urandom)}
                                        : random_entry();
        write_key(8'($urandom), k);
      end else if (r < 94) begin
        write_func(8'($urandom), $urandom);
      end else if (r < 97) begin
        it = random_item(MODE_SPARE);
        send_item(it);
      end else begin
        stray_event(1'b0);
      end
    end
  endtask

  // Stimulus.
  initial begin
    logic [SEQ_W-1:0] first;
    logic [SEQ_W-1:0] limit;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    steady      = 1'b0;
    items_sent  = 0;
    settings_used = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset window empty, nothing is read from the tables.
    send_item(random_item(MODE_SPARE));
    send_event(15'h7fff, 1'b1, 12'hfff);
    send_event(15'h0000, 1'b0, 12'h000);

    load_tables();
    settle();

    // Sixteen held presses fill the buffer; the next one overflows.
    program_regs(9'd0, 9'd20, 6'd0);
    for (int i = 0; i <= EVENT_DEPTH_DEF; i++) send_event(15'h0100 + 15'(i), 1'b1, 12'($urandom));
    settle();

    // Break entries, modifier masks and a group index wrapping past the end.
    program_regs(9'd20, 9'd24, 6'd63);
    send_event(15'h7fff, 1'b1, 12'hfff);
    send_event(15'h0000, 1'b0, 12'h000);
    send_event(15'h0005, 1'b1, 12'h001);
    send_event(15'h0005, 1'b1, 12'h000);
    send_event(15'h0005, 1'b1, 12'h801);
    send_event(15'h0006, 1'b0, 12'h000);
    settle();

    // First index beyond the table: an empty window.
    program_regs(9'd511, 9'd511, 6'd0);
    send_event(15'h0006, 1'b1, 12'h000);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p % 3 == 2);
      case (p)
        0: program_regs(9'd0, 9'd256, 6'd0);
        1: program_regs(9'd20, 9'd511, 6'd63);
        2: program_regs(9'd255, 9'd256, 6'($urandom));
        3: program_regs(9'd300, 9'd0, 6'($urandom));
        default: begin
          first = 9'($urandom_range(0, 200));
          limit = ($urandom_range(0, 4) == 0) ? 9'd256 : first + 9'($urandom_range(1, 80));
          program_regs(first, limit, 6'($urandom));
        end
      endcase
      random_phase((p == 3) ? PHASE_ITEMS / 4 : PHASE_ITEMS);
      settle();
    end

    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d items under %0d register settings after loading both tables.",
             items_sent, settings_used);
    $display("Outcomes: %0d matches, %0d prefixes held, %0d releases dropped,",
             book.outcome_tally[STATUS_MATCH], book.outcome_tally[STATUS_CONT],
             book.outcome_tally[STATUS_IGNORED]);
    $display("          %0d misses, %0d overflows, %0d writes.",
             book.outcome_tally[STATUS_FAILED], book.outcome_tally[STATUS_OVERFLOW],
             book.outcome_tally[STATUS_WRITTEN]);
    if (book.mismatches == 0 && book.awaited() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: hotkey_sequence_matcher.f
src/hsm_pkg.sv
src/hsm_match_core.sv
src/hotkey_sequence_matcher.sv
sim/testbench.sv
